// File: design/zsf_pkg.sv
// zsf_pkg: shared types, constants and helpers for the zlib stored framer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package zsf_pkg;

    // zlib stream header: deflate, 32k window, no dictionary, fastest
    localparam logic [7:0]  ZLIB_CMF    = 8'h78;
    localparam logic [7:0]  ZLIB_FLG    = 8'h01;

    // largest stored block and the adler-32 modulus
    localparam logic [15:0] BLOCK_MAX   = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one classified word travelling from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;        // first word of a stream
        logic        blk;        // first word of a block
        logic        final_blk;  // block is the final one
        logic [15:0] len;        // block length
        logic        last;       // last word of the stream
        logic [15:0] sum_high;   // adler sums after this word
        logic [15:0] sum_low;
    } entry_t;

    // output byte sequencer phases
    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_BLK0,
        PH_BLK1,
        PH_BLK2,
        PH_BLK3,
        PH_BLK4,
        PH_DATA,
        PH_TRL0,
        PH_TRL1,
        PH_TRL2,
        PH_TRL3
    } phase_t;

    // one conditional subtract, input known to be below twice the modulus
    function automatic logic [15:0] adler_reduce(input logic [16:0] v);
        logic [16:0] r;
        r = (v >= ADLER_MOD) ? (v - ADLER_MOD) : v;
        return r[15:0];
    endfunction

endpackage

// File: design/zsf_front.sv
// zsf_front: accepts payload words, tracks stream and block position,
// keeps the adler-32 sums and builds one queue entry per word; uses zsf_pkg
`timescale 1ns / 1ps

module zsf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    output zsf_pkg::entry_t entry
);
    import zsf_pkg::*;

    logic [31:0] total_length_reg;
    logic [31:0] slen_reg, slen_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] sum_low_reg, sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;

    logic        start, blk, final_blk, last;
    logic [31:0] tl_eff, left;
    logic [15:0] len, sl_cur, sh_cur, sl_new, sh_new;

    always_comb
    begin
        start     = (consumed_reg == 32'd0);
        tl_eff    = (total_length_reg == 32'd0) ? 32'd1 : total_length_reg;
        slen_next = start ? tl_eff : slen_reg;
        left      = slen_next - consumed_reg;
        blk       = (remain_reg == 16'd0);
        len       = (left < {16'd0, BLOCK_MAX}) ? left[15:0] : BLOCK_MAX;
        final_blk = (left <= {16'd0, BLOCK_MAX});
        last      = (left == 32'd1);

        sl_cur = start ? 16'd1 : sum_low_reg;
        sh_cur = start ? 16'd0 : sum_high_reg;
        sl_new = adler_reduce({1'b0, sl_cur} + {9'd0, data_byte});
        sh_new = adler_reduce({1'b0, sh_cur} + {1'b0, sl_new});

        if (last)
        begin
            consumed_next = 32'd0;
            remain_next   = 16'd0;
            sum_low_next  = 16'd1;
            sum_high_next = 16'd0;
        end
        else
        begin
            consumed_next = consumed_reg + 32'd1;
            remain_next   = (blk ? len : remain_reg) - 16'd1;
            sum_low_next  = sl_new;
            sum_high_next = sh_new;
        end

        entry.data      = data_byte;
        entry.hdr       = start;
        entry.blk       = blk;
        entry.final_blk = final_blk;
        entry.len       = len;
        entry.last      = last;
        entry.sum_high  = sh_new;
        entry.sum_low   = sl_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= 32'd1;
            slen_reg         <= 32'd0;
            consumed_reg     <= 32'd0;
            remain_reg       <= 16'd0;
            sum_low_reg      <= 16'd1;
            sum_high_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                total_length_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                slen_reg     <= slen_next;
                consumed_reg <= consumed_next;
                remain_reg   <= remain_next;
                sum_low_reg  <= sum_low_next;
                sum_high_reg <= sum_high_next;
            end
        end
    end

endmodule

// File: design/zsf_queue.sv
// zsf_queue: short first-in first-out queue of classified entries
// between front and back; uses zsf_pkg
`timescale 1ns / 1ps

module zsf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  zsf_pkg::entry_t wr_data,
    input  logic            rd_en,
    output zsf_pkg::entry_t rd_data,
    output logic            full,
    output logic            empty
);
    import zsf_pkg::*;

    entry_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: design/zsf_back.sv
// zsf_back: expands each queue entry into stream header, block header,
// data and trailer bytes through a one-word output register; uses zsf_pkg
`timescale 1ns / 1ps

module zsf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  zsf_pkg::entry_t head,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            stream_end
);
    import zsf_pkg::*;

    phase_t     ph_reg, ph_next, cur_ph;
    logic       first_reg, first_next;
    logic       ov_reg, ov_next;
    logic       fire, done;
    logic [7:0] byte_val;
    logic [7:0] out_byte_reg;
    logic       run_last_reg, stream_end_reg;

    always_comb
    begin
        if (!first_reg)
        begin
            cur_ph = ph_reg;
        end
        else if (head.hdr)
        begin
            cur_ph = PH_HDR0;
        end
        else if (head.blk)
        begin
            cur_ph = PH_BLK0;
        end
        else
        begin
            cur_ph = PH_DATA;
        end

        fire = !q_empty && (!ov_reg || pop);
        done = ((cur_ph == PH_DATA) && !head.last) || (cur_ph == PH_TRL3);

        unique case (cur_ph)
            PH_HDR0: begin byte_val = ZLIB_CMF;                 ph_next = PH_HDR1; end
            PH_HDR1: begin byte_val = ZLIB_FLG;                 ph_next = PH_BLK0; end
            PH_BLK0: begin byte_val = {7'd0, head.final_blk};   ph_next = PH_BLK1; end
            PH_BLK1: begin byte_val = head.len[7:0];            ph_next = PH_BLK2; end
            PH_BLK2: begin byte_val = head.len[15:8];           ph_next = PH_BLK3; end
            PH_BLK3: begin byte_val = ~head.len[7:0];           ph_next = PH_BLK4; end
            PH_BLK4: begin byte_val = ~head.len[15:8];          ph_next = PH_DATA; end
            PH_DATA: begin byte_val = head.data;                ph_next = PH_TRL0; end
            PH_TRL0: begin byte_val = head.sum_high[15:8];      ph_next = PH_TRL1; end
            PH_TRL1: begin byte_val = head.sum_high[7:0];       ph_next = PH_TRL2; end
            PH_TRL2: begin byte_val = head.sum_low[15:8];       ph_next = PH_TRL3; end
            PH_TRL3: begin byte_val = head.sum_low[7:0];        ph_next = PH_HDR0; end
            default: begin byte_val = head.data;                ph_next = PH_DATA; end
        endcase

        q_pop      = fire && done;
        first_next = fire ? done : first_reg;
        if (!fire)
        begin
            ph_next = ph_reg;
        end

        if (fire)
        begin
            ov_next = 1'b1;
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_HDR0;
            first_reg <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ph_reg    <= ph_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg   <= byte_val;
            run_last_reg   <= done;
            stream_end_reg <= (cur_ph == PH_TRL3);
        end
    end

    assign empty      = !ov_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

endmodule

// File: design/zlib_stored_framer_adler32_unit.sv
// zlib_stored_framer_adler32_unit: wraps payload words as a zlib stream of stored blocks
// an accepted word is written into the queue, and its first result word then enters the output register
// throughput: one output word per cycle while popped; a word expands to 1 to 12 output words
// input side takes one word per cycle until the four-entry queue fills
// reset: asynchronous active low; resets stream position and sums, total_length back to 1
`timescale 1ns / 1ps

module zlib_stored_framer_adler32_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: total_length
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // payload input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    // zlib stream output queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        stream_end
);
    import zsf_pkg::*;

    // front side: classification and adler sums happen at the accept edge
    entry_t front_entry;
    entry_t head_entry;
    logic   accept;
    logic   q_empty;
    logic   q_pop;

    assign accept = push && !full;

    zsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .data_byte   (data_byte),
        .entry       (front_entry)
    );

    // decoupling queue: the front keeps taking words while the back expands
    // headers and trailers
    zsf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_entry),
        .rd_en   (q_pop),
        .rd_data (head_entry),
        .full    (full),
        .empty   (q_empty)
    );

    // back side: byte sequencer feeding the output register
    zsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    // the trailer's final byte always closes its input word
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && stream_end |-> run_last)
        else $error("stream end without run last");

    // a new stream always opens a new block
    a_hdr_opens_blk: assert property (@(posedge clk) disable iff (!rst_n)
        accept && front_entry.hdr |-> front_entry.blk)
        else $error("stream start without block header");

    // a block never has zero length
    a_blk_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && front_entry.blk |-> front_entry.len != 16'd0)
        else $error("empty stored block");

    // every block before the final one is full size
    a_nonfinal_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && front_entry.blk && !front_entry.final_blk |-> front_entry.len == BLOCK_MAX)
        else $error("short non-final block");

endmodule

// File: sim/zlib_stored_framer_adler32_unit_tb.sv
// zlib_stored_framer_adler32_unit_tb: self-checking bench for the zlib stored-block framer
// depends on zsf_pkg (header bytes, block size, adler modulus) and the unit under test
// directed table first, then random streams and one open longest-length stream, all predicted
`timescale 1ns / 1ps

module zlib_stored_framer_adler32_unit_tb;

    import zsf_pkg::*;

    // receiver hold-off used once to back the unit up into a full input
    localparam int LONG_HOLD    = 300;
    // rough count of random payload words
    localparam int RAND_WORDS   = 500;
    localparam int DIR_ROWS     = 15;

    // one expected output word
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } zword_t;

    // one row of the directed table; typed bytes read from the top down
    typedef struct packed {
        logic        do_cfg;
        logic [31:0] cfg_val;
        logic [7:0]  data;
        logic [3:0]  n_typed;
        logic [95:0] typed;
        logic        typed_end;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        stream_end;

    // predicted zlib words still to come out, oldest first
    zword_t      zlib_expected [$];
    int          last_made;
    int          bad_words = 0;

    // framer state as the bench sees it
    logic [31:0] len_reg;
    logic [31:0] stream_len;
    logic [31:0] taken;
    logic [15:0] blk_left;
    logic [15:0] adl_a;
    logic [15:0] adl_b;

    // shared pacing controls
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    dir_row_t    dir_rows [DIR_ROWS];

    zlib_stored_framer_adler32_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_end  (stream_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // give up well past the slowest legal run
    initial
    begin
        #(30_000_000);
        $display("** zlib_stored_framer_adler32_unit: FAILED **");
        $finish;
    end

    function automatic void put_word(input logic [7:0] b, input logic fin);
        zword_t w;
        w = {b, 1'b0, fin};
        zlib_expected.insert(zlib_expected.size(), w);
        last_made++;
    endfunction

    // expand one payload word into the zlib words it causes
    function automatic void frame_byte(input logic [7:0] d);
        logic [31:0] left;
        logic [15:0] blen;
        logic [16:0] acc;
        zword_t      w;
        last_made = 0;
        // stream start: latch the length, zero length counts as one
        if (taken == 32'd0)
        begin
            stream_len = (len_reg == 32'd0) ? 32'd1 : len_reg;
            adl_a = 16'd1;
            adl_b = 16'd0;
            blk_left = 16'd0;
            put_word(ZLIB_CMF, 1'b0);
            put_word(ZLIB_FLG, 1'b0);
        end
        // block start: final flag, length and its complement, little-endian
        if (blk_left == 16'd0)
        begin
            left = stream_len - taken;
            blen = (left < {16'd0, BLOCK_MAX}) ? left[15:0] : BLOCK_MAX;
            put_word({7'd0, left <= {16'd0, BLOCK_MAX}}, 1'b0);
            put_word(blen[7:0], 1'b0);
            put_word(blen[15:8], 1'b0);
            put_word(~blen[7:0], 1'b0);
            put_word(~blen[15:8], 1'b0);
            blk_left = blen;
        end
        put_word(d, 1'b0);
        // running adler sums, each kept below the modulus
        acc = {1'b0, adl_a} + {9'd0, d};
        if (acc >= ADLER_MOD)
            acc = acc - ADLER_MOD;
        adl_a = acc[15:0];
        acc = {1'b0, adl_b} + {1'b0, adl_a};
        if (acc >= ADLER_MOD)
            acc = acc - ADLER_MOD;
        adl_b = acc[15:0];
        blk_left = blk_left - 16'd1;
        taken = taken + 32'd1;
        // stream end: big-endian trailer, then back to idle
        if (taken >= stream_len)
        begin
            put_word(adl_b[15:8], 1'b0);
            put_word(adl_b[7:0], 1'b0);
            put_word(adl_a[15:8], 1'b0);
            put_word(adl_a[7:0], 1'b1);
            taken = 32'd0;
            blk_left = 16'd0;
            adl_a = 16'd1;
            adl_b = 16'd0;
        end
        w = zlib_expected[zlib_expected.size() - 1];
        w.run_last = 1'b1;
        zlib_expected[zlib_expected.size() - 1] = w;
    endfunction

    // offer one payload word after a random gap, predict once it is taken
    task automatic send_byte(input logic [7:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        do
            @(posedge clk);
        while (full);
        frame_byte(d);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic settle();
        push <= 1'b0;
        while (zlib_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write total_length while the unit is idle
    task automatic write_len(input logic [31:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_reg = v;
    endtask

    // receiver: random pops, one long hold on request, compare each word
    initial
    begin
        int     wait_n;
        zword_t w;
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                wait_n = LONG_HOLD;
            end
            else
                wait_n = quiet ? 0 : $urandom_range(0, 4);
            if (wait_n > 0)
            begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            if (zlib_expected.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("%0t: unexpected word byte %02h last %0b end %0b",
                             $realtime, out_byte, run_last, stream_end);
            end
            else
            begin
                w = zlib_expected.pop_front();
                if (w.data !== out_byte || w.run_last !== run_last ||
                    w.stream_end !== stream_end)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"%0t: mismatch expected byte %02h last %0b end %0b,",
                                  " got byte %02h last %0b end %0b"},
                                 $realtime, w.data, w.run_last, w.stream_end,
                                 out_byte, run_last, stream_end);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t row;
        zword_t   tw;
        int       i;
        int       k;
        int       n;
        int       mid;
        int       r;
        logic [31:0] pick;

        push <= 1'b0;
        data_byte <= 8'h00;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 32'd0;

        // state after reset
        len_reg = 32'd1;
        stream_len = 32'd0;
        taken = 32'd0;
        blk_left = 16'd0;
        adl_a = 16'd1;
        adl_b = 16'd0;

        // cfg, value, data, typed count, typed bytes, trailer on the last typed byte
        dir_rows = '{
            // reset length of one, smallest and largest byte
            '{1'b0, 32'd0, 8'h00, 4'd12, 96'h78_01_01_01_00_FE_FF_00_00_01_00_01, 1'b1},
            '{1'b0, 32'd0, 8'hFF, 4'd12, 96'h78_01_01_01_00_FE_FF_FF_01_00_01_00, 1'b1},
            // zero length is taken as one
            '{1'b1, 32'd0, 8'h80, 4'd12, 96'h78_01_01_01_00_FE_FF_80_00_81_00_81, 1'b1},
            // three word stream with a length write in the middle that must wait
            '{1'b1, 32'd3, 8'h01, 4'd0, 96'd0, 1'b0},
            '{1'b1, 32'd1, 8'h02, 4'd0, 96'd0, 1'b0},
            '{1'b0, 32'd0, 8'h03, 4'd0, 96'd0, 1'b0},
            // the held write now applies
            '{1'b0, 32'd0, 8'h55, 4'd0, 96'd0, 1'b0},
            '{1'b1, 32'd2, 8'h00, 4'd0, 96'd0, 1'b0},
            '{1'b0, 32'd0, 8'hFF, 4'd0, 96'd0, 1'b0},
            '{1'b1, 32'd4, 8'h7F, 4'd0, 96'd0, 1'b0},
            '{1'b0, 32'd0, 8'h80, 4'd0, 96'd0, 1'b0},
            '{1'b0, 32'd0, 8'h01, 4'd0, 96'd0, 1'b0},
            '{1'b0, 32'd0, 8'hFE, 4'd0, 96'd0, 1'b0},
            '{1'b1, 32'd1, 8'hAA, 4'd12, 96'h78_01_01_01_00_FE_FF_AA_00_AB_00_AB, 1'b1},
            '{1'b0, 32'd0, 8'h55, 4'd0, 96'd0, 1'b0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows replace the predicted words
        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.do_cfg)
                write_len(row.cfg_val);
            send_byte(row.data);
            if (row.n_typed != 4'd0)
            begin
                for (k = 0; k < last_made; k++)
                    zlib_expected.delete(zlib_expected.size() - 1);
                for (k = 0; k < int'(row.n_typed); k++)
                begin
                    tw.data       = row.typed[95 - 8 * k -: 8];
                    tw.run_last   = (k == int'(row.n_typed) - 1);
                    tw.stream_end = row.typed_end && (k == int'(row.n_typed) - 1);
                    zlib_expected.insert(zlib_expected.size(), tw);
                end
            end
        end

        // random streams; the first one runs into the long receiver hold
        r = 0;
        i = 0;
        while (r < RAND_WORDS)
        begin
            if (i == 0)
            begin
                quiet = 1'b0;
                write_len(32'd40);
                hold_req = 1'b1;
            end
            else
            begin
                quiet = ($urandom_range(0, 7) == 0);
                // sometimes keep the length left by a mid-stream write
                if ($urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, 9);
                    if (k == 0)
                        pick = 32'd0;
                    else if (k < 8)
                        pick = $urandom_range(1, 12);
                    else
                        pick = $urandom_range(13, 60);
                    write_len(pick);
                end
            end
            i++;
            n = (len_reg == 32'd0) ? 1 : int'(len_reg);
            mid = (n > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : -1;
            for (k = 0; k < n; k++)
            begin
                if (k == mid)
                    write_len($urandom_range(0, 20));
                send_byte(8'($urandom_range(0, 255)));
                r++;
            end
        end
        quiet = 1'b0;

        // largest length: first block header only, the stream stays open
        write_len(32'hFFFF_FFFF);
        for (k = 0; k < 8; k++)
            send_byte(8'($urandom_range(0, 255)));
        write_len(32'd5);
        for (k = 0; k < 8; k++)
            send_byte(8'($urandom_range(0, 255)));

        // drain, then a short quiet window for stray words
        settle();
        repeat (16) @(posedge clk);
        if (bad_words == 0 && zlib_expected.size() == 0)
            $display("** zlib_stored_framer_adler32_unit: PASSED **");
        else
            $display("** zlib_stored_framer_adler32_unit: FAILED **");
        $finish;
    end

endmodule
